### rtl/core/iou_greedy_object_tracker_defines.svh
// Assertion helpers shared by the tracker modules.
`ifndef IOU_GREEDY_OBJECT_TRACKER_DEFINES_SVH
`define IOU_GREEDY_OBJECT_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IOGT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IOGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/iogt_pkg.sv
package iogt_pkg;

  localparam int COORD_BITS = 12;
  localparam int COUNT_BITS = 8;
  localparam int AREA_W     = 2 * COORD_BITS;
  localparam int UNI_W      = AREA_W + 1;
  localparam int IOU_FRAC   = 16;
  localparam int Q_W        = IOU_FRAC + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration register indexes
  localparam logic [1:0] CFG_IOU_THR  = 2'd0;
  localparam logic [1:0] CFG_MAX_MISS = 2'd1;
  localparam logic [1:0] CFG_MIN_HIT  = 2'd2;

  localparam logic CMD_DET = 1'b0;
  localparam logic CMD_EOF = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [63:0]           frame_time;
    logic [7:0]            det_class;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
  } item_t;

  typedef struct packed {
    logic [31:0]           track_id;
    logic [7:0]            track_class;
    logic [COORD_BITS-1:0] out_left;
    logic [COORD_BITS-1:0] out_top;
    logic [COORD_BITS-1:0] out_width;
    logic [COORD_BITS-1:0] out_height;
    logic [63:0]           first_seen;
    logic [63:0]           last_seen;
    logic [COUNT_BITS-1:0] hits;
    logic [COUNT_BITS-1:0] misses;
    logic                  none_confirmed;
    logic                  last_of_frame;
  } result_t;

  // One track table entry
  typedef struct packed {
    logic [31:0]           id;
    logic [7:0]            cls;
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
    logic [63:0]           first_time;
    logic [63:0]           last_time;
    logic [COUNT_BITS-1:0] hits;
    logic [COUNT_BITS-1:0] misses;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EVAL, S_CHK, S_DIV, S_DECIDE, S_UWR, S_NEW,
    S_ARD, S_AGE, S_EMIT, S_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd_idx;
    logic rd_pick;
    logic eval;
    logic chk;
    logic div_cmp;
    logic idx_inc;
    logic upd;
    logic new_ent;
    logic age;
    logic emit;
    logic flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_idx;
    logic cand;
    logic div_done;
    logic pick_found;
    logic emit_ok;
    logic out_free;
  } stat_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // Overlap of two spans; end points carry one extra bit
  function automatic logic [COORD_BITS-1:0] span_overlap(
    input logic [COORD_BITS-1:0] a0, input logic [COORD_BITS-1:0] aw,
    input logic [COORD_BITS-1:0] b0, input logic [COORD_BITS-1:0] bw);
    logic [COORD_BITS:0] lo, hi, ae, be, d;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae = {1'b0, a0} + {1'b0, aw};
    be = {1'b0, b0} + {1'b0, bw};
    hi = (ae < be) ? ae : be;
    d  = hi - lo;
    return (hi > lo) ? d[COORD_BITS-1:0] : '0;
  endfunction

  function automatic result_t to_result(input entry_t e, input logic last);
    result_t r;
    r.track_id       = e.id;
    r.track_class    = e.cls;
    r.out_left       = e.left;
    r.out_top        = e.top;
    r.out_width      = e.width;
    r.out_height     = e.height;
    r.first_seen     = e.first_time;
    r.last_seen      = e.last_time;
    r.hits           = e.hits;
    r.misses         = e.misses;
    r.none_confirmed = 1'b0;
    r.last_of_frame  = last;
    return r;
  endfunction

endpackage

### rtl/core/iogt_div.sv
// Restoring divider, one quotient bit per cycle: floor(numer * 2^16 / denom).
// Expects numer <= denom and denom != 0.
module iogt_div
  import iogt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [AREA_W-1:0] numer,
  input  logic [UNI_W-1:0]  denom,
  output logic [Q_W-1:0]    quot,
  output logic              done
);

  localparam int REM_W = UNI_W + 1;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [REM_W-1:0] rem;
  logic [UNI_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;
  logic [REM_W-1:0] diff;

  // Trial subtract
  assign ge   = rem >= {1'b0, den};
  assign diff = ge ? (rem - {1'b0, den}) : rem;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= REM_W'(numer);
      den  <= denom;
      quot <= '0;
    end else if (busy) begin
      rem  <= {diff[REM_W-2:0], 1'b0};
      quot <= {quot[Q_W-2:0], ge};
    end
  end

endmodule

### rtl/core/iogt_ctrl.sv
`include "iou_greedy_object_tracker_defines.svh"

module iogt_ctrl
  import iogt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  logic  item_eof,
  output logic  item_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = (item_eof == CMD_EOF) ? S_ARD : S_RD;
        end
      end
      S_RD: begin
        cmd.rd_idx = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (st.cand) begin
          state_next = S_DIV;
        end else if (st.last_idx) begin
          state_next = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.div_cmp = 1'b1;
          if (st.last_idx) begin
            state_next = S_DECIDE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      S_DECIDE: begin
        if (st.pick_found) begin
          cmd.rd_pick = 1'b1;
          state_next  = S_UWR;
        end else begin
          state_next = S_NEW;
        end
      end
      S_UWR: begin
        cmd.upd    = 1'b1;
        state_next = S_IDLE;
      end
      S_NEW: begin
        cmd.new_ent = 1'b1;
        state_next  = S_IDLE;
      end
      S_ARD: begin
        cmd.rd_idx = 1'b1;
        state_next = S_AGE;
      end
      S_AGE: begin
        cmd.age    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.emit_ok) begin
          if (st.last_idx) begin
            state_next = S_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_ARD;
          end
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `IOGT_ASSERT_NOW(a_div_done_in_div, st.div_done, state == S_DIV, "divide finished outside S_DIV")
  `IOGT_ASSERT_NEXT(a_flush_to_idle, (state == S_FLUSH) && st.out_free, state == S_IDLE, "flush did not end frame")
  `IOGT_ASSERT_NEXT(a_load_stalls, (state == S_IDLE) && item_valid, item_stall, "no stall after request")

endmodule

### rtl/core/iogt_dp.sv
`include "iou_greedy_object_tracker_defines.svh"

module iogt_dp
  import iogt_pkg::*;
#(
  parameter int MAX_TRACKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  output result_t     result,
  output logic        result_valid,
  input  logic        result_stall,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       st
);

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  // Configuration
  logic [15:0]           iou_thr;
  logic [COUNT_BITS-1:0] max_miss;
  logic [COUNT_BITS-1:0] min_hit;

  // Request and scan state
  item_t            in_r;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] pick;
  logic [IDX_W-1:0] free_slot;
  logic             pick_found;
  logic             free_found;
  logic [Q_W-1:0]   best;
  logic [31:0]      id_cnt;

  // Per-slot flags
  logic [MAX_TRACKS-1:0] valid;
  logic [MAX_TRACKS-1:0] born;
  logic [MAX_TRACKS-1:0] matched;

  // Track table
  entry_t           mem [MAX_TRACKS];
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // IoU terms
  logic [AREA_W-1:0] inter;
  logic [AREA_W-1:0] area_a;
  logic [AREA_W-1:0] area_b;
  logic              eval_ok;
  logic [UNI_W-1:0]  uni;
  logic              cand_now;
  logic [Q_W-1:0]    quot;
  logic              div_done;

  // Aging and report staging
  logic [COUNT_BITS-1:0] age_misses;
  logic                  pre_frame;
  logic                  keep;
  entry_t                aged;
  entry_t                cand;
  logic                  cand_rep;
  entry_t                hold;
  logic                  hold_full;
  logic                  out_free;
  logic                  emit_ok;
  logic                  out_load;
  result_t               none_res;

  assign uni       = {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter};
  assign cand_now  = eval_ok && (uni != '0);
  assign pre_frame = valid[idx] && !born[idx] && !matched[idx];
  assign age_misses = pre_frame ? sat_inc(rd_data.misses) : rd_data.misses;
  assign keep      = valid[idx] && (age_misses <= max_miss);
  assign out_free  = !result_valid || !result_stall;
  assign emit_ok   = !cand_rep || !hold_full || out_free;
  assign out_load  = (cmd.emit && cand_rep && hold_full && out_free) ||
                     (cmd.flush && out_free);

  assign st.last_idx   = (idx == IDX_W'(MAX_TRACKS - 1));
  assign st.cand       = cand_now;
  assign st.div_done   = div_done;
  assign st.pick_found = pick_found;
  assign st.emit_ok    = emit_ok;
  assign st.out_free   = out_free;

  iogt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.chk && cand_now),
    .numer (inter),
    .denom (uni),
    .quot  (quot),
    .done  (div_done)
  );

  // Aged copy of the slot under scan
  always_comb begin
    aged        = rd_data;
    aged.misses = age_misses;
  end

  // Frame result when no track qualifies
  always_comb begin
    none_res                = '0;
    none_res.none_confirmed = 1'b1;
    none_res.last_of_frame  = 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_thr  <= 16'd19661;
      max_miss <= COUNT_BITS'(5);
      min_hit  <= COUNT_BITS'(3);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IOU_THR:  iou_thr  <= cfg_data;
        CFG_MAX_MISS: max_miss <= cfg_data[COUNT_BITS-1:0];
        CFG_MIN_HIT:  min_hit  <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (cmd.upd) begin
      wr_en             = 1'b1;
      wr_addr           = pick;
      wr_data.cls       = in_r.det_class;
      wr_data.left      = in_r.box_left;
      wr_data.top       = in_r.box_top;
      wr_data.width     = in_r.box_width;
      wr_data.height    = in_r.box_height;
      wr_data.last_time = in_r.frame_time;
      wr_data.hits      = sat_inc(rd_data.hits);
      wr_data.misses    = '0;
    end else if (cmd.new_ent && free_found) begin
      wr_en              = 1'b1;
      wr_addr            = free_slot;
      wr_data.id         = id_cnt;
      wr_data.cls        = in_r.det_class;
      wr_data.left       = in_r.box_left;
      wr_data.top        = in_r.box_top;
      wr_data.width      = in_r.box_width;
      wr_data.height     = in_r.box_height;
      wr_data.first_time = in_r.frame_time;
      wr_data.last_time  = in_r.frame_time;
      wr_data.hits       = COUNT_BITS'(1);
      wr_data.misses     = '0;
    end else if (cmd.age && valid[idx]) begin
      wr_en          = 1'b1;
      wr_data.misses = age_misses;
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_idx || cmd.rd_pick) begin
      rd_data <= mem[cmd.rd_pick ? pick : idx];
    end
  end

  // Slot flags and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      born    <= '0;
      matched <= '0;
      id_cnt  <= '0;
    end else begin
      if (cmd.upd) begin
        matched[pick] <= 1'b1;
      end
      if (cmd.new_ent && free_found) begin
        valid[free_slot]   <= 1'b1;
        born[free_slot]    <= 1'b1;
        matched[free_slot] <= 1'b0;
        id_cnt             <= id_cnt + 1'b1;
      end
      if (cmd.age) begin
        valid[idx]   <= keep;
        born[idx]    <= 1'b0;
        matched[idx] <= 1'b0;
      end
    end
  end

  // Scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r       <= item;
      idx        <= '0;
      best       <= {1'b0, iou_thr};
      pick_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.eval) begin
      inter   <= span_overlap(in_r.box_left, in_r.box_width, rd_data.left, rd_data.width) *
                 span_overlap(in_r.box_top, in_r.box_height, rd_data.top, rd_data.height);
      area_a  <= in_r.box_width * in_r.box_height;
      area_b  <= rd_data.width * rd_data.height;
      eval_ok <= pre_frame && (rd_data.cls == in_r.det_class);
      if (!valid[idx] && !free_found) begin
        free_slot  <= idx;
        free_found <= 1'b1;
      end
    end
    if (cmd.div_cmp && (quot > best)) begin
      best       <= quot;
      pick       <= idx;
      pick_found <= 1'b1;
    end
    if (cmd.age) begin
      cand <= aged;
    end
  end

  // Report staging: hold one track back so the frame's last one can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_rep     <= 1'b0;
      hold_full    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.age) begin
        cand_rep <= keep && (rd_data.hits >= min_hit);
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.emit && cand_rep) begin
        if (!hold_full) begin
          hold      <= cand;
          hold_full <= 1'b1;
        end else if (out_free) begin
          result <= to_result(hold, 1'b0);
          hold   <= cand;
        end
      end
      if (cmd.flush && out_free) begin
        result    <= hold_full ? to_result(hold, 1'b1) : none_res;
        hold_full <= 1'b0;
      end
    end
  end

  `IOGT_ASSERT_NOW(a_born_not_matched, 1'b1, (born & matched) == '0, "slot born and matched at once")
  `IOGT_ASSERT_NEXT(a_flush_empties, cmd.flush && out_free, !hold_full, "held track survived flush")
  `IOGT_ASSERT_NOW(a_quot_range, div_done, quot <= Q_W'(65536), "IoU above one")

endmodule

### rtl/core/iou_greedy_object_tracker.sv
// Detection: scans every slot, running the bit-serial IoU divider for each same-class
//   pre-frame candidate with a nonzero union; the table memory port scans one slot at a time.
// End of frame: scans every slot and waits on output stalls; results leave through
//   a one-entry output register, the last one after the scan ends.
// One request at a time. Reset (rst, synchronous) empties the table and the output
//   register, zeroes the id counter and loads the register defaults; no clearing pass.
module iou_greedy_object_tracker
  import iogt_pkg::*;
#(
  parameter int MAX_TRACKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  iogt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_eof   (item.cmd),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  iogt_dp #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

### tb/sv/testbench.sv
module testbench;
  import iogt_pkg::*;

  localparam int NUM_TRACKS = 32;
  // cfg index with no register behind it; writes must be ignored
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 1000;
  localparam int HOLD_CYCLES   = 600;
  localparam int ITEM_W        = $bits(item_t);

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  iou_greedy_object_tracker #(.MAX_TRACKS(NUM_TRACKS)) DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the track table
  bit                    trk_valid [NUM_TRACKS];
  bit                    trk_matched [NUM_TRACKS];
  bit                    trk_born [NUM_TRACKS];
  logic [31:0]           trk_id [NUM_TRACKS];
  logic [7:0]            trk_class [NUM_TRACKS];
  logic [COORD_BITS-1:0] trk_box [NUM_TRACKS][4];
  logic [63:0]           trk_first [NUM_TRACKS];
  logic [63:0]           trk_last [NUM_TRACKS];
  logic [COUNT_BITS-1:0] trk_hits [NUM_TRACKS];
  logic [COUNT_BITS-1:0] trk_misses [NUM_TRACKS];
  logic [31:0]           next_id;
  logic [15:0]           iou_thr;
  logic [7:0]            miss_limit;
  logic [7:0]            hit_floor;

  result_t pending_tracks[$];
  int      errors;
  int      send_idle;
  int      recv_idle;
  int      hold_asked;
  logic [63:0] frame_now;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } plan_row_t;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

  function automatic bit [63:0] span_len(bit [63:0] a0, bit [63:0] aw,
                                         bit [63:0] b0, bit [63:0] bw);
    bit [63:0] lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + aw) < (b0 + bw)) ? a0 + aw : b0 + bw;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  // Q1.16 overlap ratio of a detection against a stored track box
  function automatic bit [63:0] overlap_ratio(item_t d, int s);
    bit [63:0] inter, uni;
    inter = span_len(64'(d.box_left), 64'(d.box_width),
                     64'(trk_box[s][0]), 64'(trk_box[s][2])) *
            span_len(64'(d.box_top), 64'(d.box_height),
                     64'(trk_box[s][1]), 64'(trk_box[s][3]));
    uni = 64'(d.box_width) * 64'(d.box_height) +
          64'(trk_box[s][2]) * 64'(trk_box[s][3]) - inter;
    if (uni == 0) return 64'd0;
    return (inter << 16) / uni;
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Track table update for one accepted request; queues frame reports
  task automatic track_update(input item_t it, input bit typed, input result_t want);
    int        pick;
    int        n;
    bit [63:0] best, v;
    result_t   r;
    pick = -1;
    n = 0;
    if (it.cmd == CMD_DET) begin
      best = 64'(iou_thr);
      for (int s = 0; s < NUM_TRACKS; s++) begin
        if (!trk_valid[s] || trk_born[s] || trk_matched[s]) continue;
        if (trk_class[s] != it.det_class) continue;
        v = overlap_ratio(it, s);
        if (v > best) begin
          best = v;
          pick = s;
        end
      end
      if (pick >= 0) begin
        trk_box[pick] = '{it.box_left, it.box_top, it.box_width, it.box_height};
        trk_last[pick] = it.frame_time;
        trk_hits[pick] = bump(trk_hits[pick]);
        trk_misses[pick] = '0;
        trk_matched[pick] = 1'b1;
      end else begin
        for (int s = 0; s < NUM_TRACKS; s++) begin
          if (!trk_valid[s]) begin
            trk_valid[s] = 1'b1;
            trk_id[s] = next_id;
            next_id = next_id + 32'd1;
            trk_class[s] = it.det_class;
            trk_box[s] = '{it.box_left, it.box_top, it.box_width, it.box_height};
            trk_first[s] = it.frame_time;
            trk_last[s] = it.frame_time;
            trk_hits[s] = COUNT_BITS'(1);
            trk_misses[s] = '0;
            trk_born[s] = 1'b1;
            trk_matched[s] = 1'b0;
            break;
          end
        end
      end
      return;
    end
    // end of frame: age, retire, then report
    for (int s = 0; s < NUM_TRACKS; s++) begin
      if (trk_valid[s] && !trk_born[s] && !trk_matched[s])
        trk_misses[s] = bump(trk_misses[s]);
      if (trk_valid[s] && trk_misses[s] > miss_limit) trk_valid[s] = 1'b0;
      trk_born[s] = 1'b0;
      trk_matched[s] = 1'b0;
    end
    for (int s = 0; s < NUM_TRACKS; s++) begin
      if (!trk_valid[s] || trk_hits[s] < hit_floor) continue;
      r = '{track_id: trk_id[s], track_class: trk_class[s],
            out_left: trk_box[s][0], out_top: trk_box[s][1],
            out_width: trk_box[s][2], out_height: trk_box[s][3],
            first_seen: trk_first[s], last_seen: trk_last[s],
            hits: trk_hits[s], misses: trk_misses[s],
            none_confirmed: 1'b0, last_of_frame: 1'b0};
      pending_tracks = {pending_tracks, r};
      n++;
    end
    if (n == 0) begin
      r = '0;
      r.none_confirmed = 1'b1;
      r.last_of_frame = 1'b1;
      pending_tracks = {pending_tracks, (typed ? want : r)};
    end else begin
      pending_tracks[$].last_of_frame = 1'b1;
    end
  endtask

  // Offer one request; called and returns at a falling edge
  task automatic send_req(input item_t it, input bit typed = 0, input result_t want = '0);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    track_update(it, typed, want);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    item_valid <= 1'b0;
    wait (pending_tracks.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IOU_THR:  iou_thr = val;
      CFG_MAX_MISS: miss_limit = val[7:0];
      CFG_MIN_HIT:  hit_floor = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic item_t make_req(logic cmd, logic [63:0] ts, logic [7:0] cls,
                                     int l, int t, int w, int h);
    item_t it;
    it.cmd = cmd;
    it.frame_time = ts;
    it.det_class = cls;
    it.box_left = COORD_BITS'(l);
    it.box_top = COORD_BITS'(t);
    it.box_width = COORD_BITS'(w);
    it.box_height = COORD_BITS'(h);
    return it;
  endfunction

  // Detection near an existing track, somewhere new, or with random fields
  function automatic item_t scene_det();
    item_t it;
    int    s;
    it = make_req(CMD_DET, frame_now, 8'($urandom_range(0, 3)), $urandom_range(0, 3800),
                  $urandom_range(0, 3800), $urandom_range(10, 300), $urandom_range(10, 300));
    s = $urandom_range(0, NUM_TRACKS - 1);
    if ($urandom_range(99) < 70 && trk_valid[s]) begin
      it.det_class = trk_class[s];
      it.box_left = COORD_BITS'(int'(trk_box[s][0]) + int'($urandom_range(0, 6)) - 3);
      it.box_top = COORD_BITS'(int'(trk_box[s][1]) + int'($urandom_range(0, 6)) - 3);
      it.box_width = COORD_BITS'(int'(trk_box[s][2]) + int'($urandom_range(0, 6)) - 3);
      it.box_height = COORD_BITS'(int'(trk_box[s][3]) + int'($urandom_range(0, 6)) - 3);
    end else if ($urandom_range(99) < 10) begin
      it.det_class = 8'($urandom);
      it.box_left = COORD_BITS'($urandom);
      it.box_top = COORD_BITS'($urandom);
      it.box_width = COORD_BITS'($urandom);
      it.box_height = COORD_BITS'($urandom);
    end
    return it;
  endfunction

  // Random frames: up to six detections, then the end-of-frame request
  task automatic run_frames(input int budget);
    int    sent;
    int    ndet;
    item_t it;
    sent = 0;
    while (sent < budget) begin
      ndet = $urandom_range(0, 6);
      frame_now = ($urandom_range(99) < 5) ? {$urandom, $urandom}
                                            : frame_now + 64'($urandom_range(1, 40000000));
      for (int k = 0; k < ndet; k++) begin
        send_req(scene_det());
        sent++;
      end
      // end of frame with junk in the unused fields
      it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
      it.cmd = CMD_EOF;
      send_req(it);
      sent++;
    end
  endtask

  // Result sink: stall pattern plus one long hold-off on request
  initial begin
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked > hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      result_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_tracks.size() == 0) begin
        $error("unexpected result id=%0d", result.track_id);
        errors++;
      end else begin
        want = pending_tracks.pop_front();
        if (result.track_id !== want.track_id) begin
          $error("track_id exp %0d got %0d", want.track_id, result.track_id); errors++;
        end
        if (result.track_class !== want.track_class) begin
          $error("track_class exp %0d got %0d", want.track_class, result.track_class);
          errors++;
        end
        if (result.out_left !== want.out_left) begin
          $error("out_left exp %0d got %0d", want.out_left, result.out_left); errors++;
        end
        if (result.out_top !== want.out_top) begin
          $error("out_top exp %0d got %0d", want.out_top, result.out_top); errors++;
        end
        if (result.out_width !== want.out_width) begin
          $error("out_width exp %0d got %0d", want.out_width, result.out_width); errors++;
        end
        if (result.out_height !== want.out_height) begin
          $error("out_height exp %0d got %0d", want.out_height, result.out_height);
          errors++;
        end
        if (result.first_seen !== want.first_seen) begin
          $error("first_seen exp %0d got %0d", want.first_seen, result.first_seen);
          errors++;
        end
        if (result.last_seen !== want.last_seen) begin
          $error("last_seen exp %0d got %0d", want.last_seen, result.last_seen); errors++;
        end
        if (result.hits !== want.hits) begin
          $error("hits exp %0d got %0d", want.hits, result.hits); errors++;
        end
        if (result.misses !== want.misses) begin
          $error("misses exp %0d got %0d", want.misses, result.misses); errors++;
        end
        if (result.none_confirmed !== want.none_confirmed) begin
          $error("none_confirmed exp %0d got %0d", want.none_confirmed,
                 result.none_confirmed);
          errors++;
        end
        if (result.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame exp %0d got %0d", want.last_of_frame, result.last_of_frame);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    plan_row_t   plan[$];
    plan_row_t   row;
    result_t     nothing;
    logic [15:0] thr_set [5];
    logic [7:0]  miss_set [5];
    logic [7:0]  hit_set [5];

    errors = 0;
    hold_asked = 0;
    send_idle = 25;
    recv_idle = 79;
    frame_now = 64'd1000;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IOU_THR;
    cfg_data = '0;
    foreach (trk_valid[s]) begin
      trk_valid[s] = 0;
      trk_matched[s] = 0;
      trk_born[s] = 0;
    end
    next_id = '0;
    iou_thr = 16'd19661;
    miss_limit = 8'd5;
    hit_floor = 8'd3;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames at the reset settings
    nothing = '0;
    nothing.none_confirmed = 1'b1;
    nothing.last_of_frame = 1'b1;
    row.typed = 1;
    row.want = nothing;
    row.it = make_req(CMD_EOF, '1, 8'hff, 4095, 4095, 4095, 4095);  // empty table
    plan = {plan, row};
    row.typed = 0;
    row.it = make_req(CMD_DET, 64'd0, 8'd0, 0, 0, 0, 0);            // zero area
    plan = {plan, row};
    row.it = make_req(CMD_DET, 64'd0, 8'd255, 4095, 4095, 4095, 4095);
    plan = {plan, row};
    row.it = make_req(CMD_DET, 64'd0, 8'd7, 100, 100, 50, 50);
    plan = {plan, row};
    row.it = make_req(CMD_EOF, 64'd0, 8'd0, 0, 0, 0, 0);
    plan = {plan, row};
    row.it = make_req(CMD_DET, '1, 8'd7, 100, 100, 50, 50);          // exact match
    plan = {plan, row};
    row.it = make_req(CMD_DET, '1, 8'd0, 0, 0, 0, 0);                // union of zero
    plan = {plan, row};
    row.it = make_req(CMD_DET, '1, 8'd7, 102, 100, 50, 50);          // track already taken
    plan = {plan, row};
    row.it = make_req(CMD_DET, '1, 8'd255, 4095, 4095, 4095, 4095);
    plan = {plan, row};
    row.it = make_req(CMD_EOF, '1, 8'd0, 0, 0, 0, 0);
    plan = {plan, row};
    row.it = make_req(CMD_DET, 64'd5000, 8'd7, 101, 100, 50, 50);
    plan = {plan, row};
    row.it = make_req(CMD_DET, 64'd5000, 8'd7, 100, 101, 50, 50);    // takes the track the tie left
    plan = {plan, row};
    row.it = make_req(CMD_DET, 64'd5000, 8'd255, 4095, 4095, 4095, 4095);
    plan = {plan, row};
    row.it = make_req(CMD_EOF, 64'd5000, 8'd0, 0, 0, 0, 0);          // hits reach 3
    plan = {plan, row};
    foreach (plan[k]) send_req(plan[k].it, plan[k].typed, plan[k].want);

    // Settings per random phase, extremes included; index 3 must do nothing
    thr_set  = '{16'd19661, 16'd65535, 16'd0, 16'd32768, 16'd8000};
    miss_set = '{8'd5, 8'd254, 8'd0, 8'd2, 8'd254};
    hit_set  = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd0};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2) begin
        send_idle = 79;
        recv_idle = 25;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CFG_IOU_THR, thr_set[ph]);
      write_reg(CFG_MAX_MISS, {8'h00, miss_set[ph]});
      write_reg(CFG_MIN_HIT, {8'h00, hit_set[ph]});
      if (ph == 1) begin
        write_reg(CFG_SPARE, 16'hffff);
        hold_asked++;
      end
      run_frames(27);
    end

    item_valid <= 1'b0;
    wait (pending_tracks.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_tracks.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/iogt_pkg.sv
rtl/core/iogt_div.sv
rtl/core/iogt_ctrl.sv
rtl/core/iogt_dp.sv
rtl/core/iou_greedy_object_tracker.sv
tb/sv/testbench.sv
